### sv/histogram_binning_counter_defines.svh
// assertion macros shared by the histogram blocks
`ifndef HISTOGRAM_BINNING_COUNTER_DEFINES_SVH
`define HISTOGRAM_BINNING_COUNTER_DEFINES_SVH

`ifndef ASSERT_OFF

// same-cycle implication, disabled in reset
`define HBC_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// next-cycle implication, disabled in reset
`define HBC_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define HBC_ASSERT_IMPL(label, clk_s, rstn_s, ante, cons)
`define HBC_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons)

`endif

`endif

### sv/hbc_pkg.sv
package hbc_pkg;

    // defaults for the top level parameters
    localparam int DEF_MAX_BINS    = 64;
    localparam int DEF_COUNT_WIDTH = 32;

    // fixed field widths
    localparam int VALUE_W   = 32;
    localparam int BINS_W    = 7;
    localparam int INDEX_W   = 6;
    localparam int TOTAL_W   = 32;
    localparam int CFG_W     = 32;
    localparam int CFG_SEL_W = 2;

    // configuration register indexes
    localparam logic [CFG_SEL_W-1:0] REG_RANGE_LOW   = 2'd0;
    localparam logic [CFG_SEL_W-1:0] REG_RANGE_HIGH  = 2'd1;
    localparam logic [CFG_SEL_W-1:0] REG_BINS_IN_USE = 2'd2;

    // item function codes
    localparam logic FUNC_ADD  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // classifier status toward the top level
    typedef struct packed {
        logic busy;
        logic done;
    } hbc_cls_stat_t;

    // request into the count update stage
    typedef struct packed {
        logic valid;
        logic is_read;
        logic no_store;
    } hbc_req_t;

endpackage

### sv/hbc_ram.sv
module hbc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### sv/hbc_classify.sv
`include "histogram_binning_counter_defines.svh"

module hbc_classify #(
    parameter int MAX_BINS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                go,
    input  logic signed [hbc_pkg::VALUE_W-1:0]  sample_value,
    input  logic signed [hbc_pkg::VALUE_W-1:0]  range_low,
    input  logic signed [hbc_pkg::VALUE_W-1:0]  range_high,
    input  logic [hbc_pkg::BINS_W-1:0]          bins_in_use,
    output hbc_pkg::hbc_cls_stat_t              stat,
    output logic [$clog2(MAX_BINS)-1:0]         bin
);

    import hbc_pkg::*;

    localparam int QW = $clog2(MAX_BINS);
    localparam int SW = $clog2(QW + 1);
    localparam int NW = VALUE_W + BINS_W;

    typedef enum logic [1:0] {C_IDLE, C_MUL, C_DIV, C_DONE} state_t;

    state_t              state_reg;
    logic [VALUE_W-1:0]  diff_reg;
    logic [VALUE_W-1:0]  den_reg;
    logic [BINS_W-1:0]   bins_reg;
    logic [VALUE_W-1:0]  rem_reg;
    logic [QW-1:0]       lo_reg;
    logic [QW-1:0]       quot_reg;
    logic [SW-1:0]       step_reg;

    logic               empty_range;
    logic               below;
    logic               above;
    logic [VALUE_W-1:0] diff;
    logic [VALUE_W-1:0] den;
    logic [BINS_W-1:0]  eff_bins;
    logic [NW-1:0]      prod;
    logic [VALUE_W:0]   trial;
    logic               fits;

    // range checks and offsets of the incoming sample
    assign empty_range = (range_high <= range_low);
    assign below       = (sample_value < range_low);
    assign above       = (sample_value >= range_high);
    assign diff        = sample_value - range_low;
    assign den         = range_high - range_low;

    // bins in use limited to 1..MAX_BINS
    always_comb
    begin
        if (bins_in_use == '0)
        begin
            eff_bins = BINS_W'(1);
        end
        else if (32'(bins_in_use) > 32'(MAX_BINS))
        begin
            eff_bins = BINS_W'(MAX_BINS);
        end
        else
        begin
            eff_bins = bins_in_use;
        end
    end

    // scaled offset, then one quotient bit per divide step
    assign prod  = NW'(diff_reg) * NW'(bins_reg);
    assign trial = {rem_reg, lo_reg[QW-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            diff_reg  <= '0;
            den_reg   <= '0;
            bins_reg  <= '0;
            rem_reg   <= '0;
            lo_reg    <= '0;
            quot_reg  <= '0;
            step_reg  <= '0;
        end
        else
        begin
            case (state_reg)
                C_IDLE:
                begin
                    if (go)
                    begin
                        diff_reg <= diff;
                        den_reg  <= den;
                        bins_reg <= eff_bins;
                        if (empty_range || below)
                        begin
                            quot_reg  <= '0;
                            state_reg <= C_DONE;
                        end
                        else if (above)
                        begin
                            quot_reg  <= QW'(eff_bins - BINS_W'(1));
                            state_reg <= C_DONE;
                        end
                        else
                        begin
                            state_reg <= C_MUL;
                        end
                    end
                end
                C_MUL:
                begin
                    rem_reg   <= VALUE_W'(prod >> QW);
                    lo_reg    <= prod[QW-1:0];
                    quot_reg  <= '0;
                    step_reg  <= '0;
                    state_reg <= C_DIV;
                end
                C_DIV:
                begin
                    rem_reg  <= fits ? VALUE_W'(trial - {1'b0, den_reg}) : VALUE_W'(trial);
                    lo_reg   <= lo_reg << 1;
                    quot_reg <= QW'({quot_reg, fits});
                    if (step_reg == SW'(QW - 1))
                    begin
                        state_reg <= C_DONE;
                    end
                    else
                    begin
                        step_reg <= step_reg + SW'(1);
                    end
                end
                C_DONE:
                begin
                    state_reg <= C_IDLE;
                end
                default:
                begin
                    state_reg <= C_IDLE;
                end
            endcase
        end
    end

    assign stat.busy = (state_reg != C_IDLE);
    assign stat.done = (state_reg == C_DONE);
    assign bin       = quot_reg;

    // the finished bin always lies inside the bins in use
    `HBC_ASSERT_IMPL(a_bin_in_range, clk, rst_n, state_reg == C_DONE, 32'(quot_reg) < 32'(bins_reg))

endmodule

### sv/hbc_update.sv
`include "histogram_binning_counter_defines.svh"

module hbc_update #(
    parameter int MAX_BINS    = 64,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hbc_pkg::hbc_req_t                 req,
    input  logic [$clog2(MAX_BINS)-1:0]       req_addr,
    input  logic [hbc_pkg::INDEX_W-1:0]       req_index,
    output logic                              ram_rd_en,
    output logic [$clog2(MAX_BINS)-1:0]       ram_rd_addr,
    input  logic [COUNT_WIDTH-1:0]            ram_rd_data,
    output logic                              ram_wr_en,
    output logic [$clog2(MAX_BINS)-1:0]       ram_wr_addr,
    output logic [COUNT_WIDTH-1:0]            ram_wr_data,
    output logic                              busy,
    output logic                              done,
    output logic [hbc_pkg::INDEX_W-1:0]       bin_index,
    output logic [hbc_pkg::TOTAL_W-1:0]       bin_total
);

    import hbc_pkg::*;

    localparam int AW = $clog2(MAX_BINS);

    typedef enum logic [1:0] {U_CLEAR, U_IDLE, U_WAIT} state_t;

    state_t                 state_reg;
    logic [AW-1:0]          clr_addr_reg;
    logic                   is_read_reg;
    logic                   no_store_reg;
    logic [AW-1:0]          addr_reg;
    logic [INDEX_W-1:0]     index_reg;
    logic                   done_reg;
    logic [INDEX_W-1:0]     bin_index_reg;
    logic [TOTAL_W-1:0]     bin_total_reg;

    logic [COUNT_WIDTH-1:0] count_next;
    logic [COUNT_WIDTH-1:0] total_src;
    logic [TOTAL_W-1:0]     total_next;

    // saturating increment of the stored count
    assign count_next = (ram_rd_data == '1) ? ram_rd_data : ram_rd_data + COUNT_WIDTH'(1);
    assign total_src  = is_read_reg ? ram_rd_data : count_next;

    // fit the count into the result field, zero when nothing is stored at the index
    generate
        if (COUNT_WIDTH > TOTAL_W)
        begin : g_wide
            assign total_next = (no_store_reg) ? '0 :
                                (|total_src[COUNT_WIDTH-1:TOTAL_W]) ? '1 :
                                total_src[TOTAL_W-1:0];
        end
        else
        begin : g_narrow
            assign total_next = no_store_reg ? '0 : TOTAL_W'(total_src);
        end
    endgenerate

    // memory port control
    assign ram_rd_en   = req.valid && (state_reg == U_IDLE);
    assign ram_rd_addr = req_addr;
    assign ram_wr_en   = (state_reg == U_CLEAR) || ((state_reg == U_WAIT) && !is_read_reg);
    assign ram_wr_addr = (state_reg == U_CLEAR) ? clr_addr_reg : addr_reg;
    assign ram_wr_data = (state_reg == U_CLEAR) ? '0 : count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= U_CLEAR;
            clr_addr_reg  <= '0;
            is_read_reg   <= 1'b0;
            no_store_reg  <= 1'b0;
            addr_reg      <= '0;
            index_reg     <= '0;
            done_reg      <= 1'b0;
            bin_index_reg <= '0;
            bin_total_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                U_CLEAR:
                begin
                    if (clr_addr_reg == AW'(MAX_BINS - 1))
                    begin
                        state_reg <= U_IDLE;
                    end
                    else
                    begin
                        clr_addr_reg <= clr_addr_reg + AW'(1);
                    end
                end
                U_IDLE:
                begin
                    if (req.valid)
                    begin
                        is_read_reg  <= req.is_read;
                        no_store_reg <= req.no_store;
                        addr_reg     <= req_addr;
                        index_reg    <= req_index;
                        state_reg    <= U_WAIT;
                    end
                end
                U_WAIT:
                begin
                    done_reg      <= 1'b1;
                    bin_index_reg <= index_reg;
                    bin_total_reg <= total_next;
                    state_reg     <= U_IDLE;
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    assign busy      = (state_reg != U_IDLE);
    assign done      = done_reg;
    assign bin_index = bin_index_reg;
    assign bin_total = bin_total_reg;

    // done drops again after every result beat
    `HBC_ASSERT_NEXT(a_done_single, clk, rst_n, done_reg, !done_reg)
    // write-back goes to the entry that was read the cycle before
    `HBC_ASSERT_IMPL(a_wb_addr, clk, rst_n, (state_reg == U_WAIT) && ram_wr_en, ram_wr_addr == $past(ram_rd_addr))
    // no request arrives while an update or the clearing pass runs
    `HBC_ASSERT_IMPL(a_req_idle, clk, rst_n, req.valid, state_reg == U_IDLE)

endmodule

### sv/histogram_binning_counter.sv
// channel   | handshake       | payload
// ----------+-----------------+--------------------------------------
// config    | cfg_we          | cfg_index, cfg_data
// item in   | start, busy     | func, sample_value, read_index
// result    | done            | bin_index, bin_total
//
// after reset the count memory is swept to zero while busy is high
// a read item goes straight to a read of the count memory; a sample outside the
// range or with an empty range skips the scaling and the divider; any other sample
// passes the shift-subtract divider, one quotient bit a cycle, and is then
// followed by the read-modify-write of the count memory
// each result beat shows on done for one cycle and is never held off
module histogram_binning_counter #(
    parameter int MAX_BINS    = hbc_pkg::DEF_MAX_BINS,
    parameter int COUNT_WIDTH = hbc_pkg::DEF_COUNT_WIDTH
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [hbc_pkg::CFG_SEL_W-1:0]      cfg_index,
    input  logic [hbc_pkg::CFG_W-1:0]          cfg_data,
    input  logic                               start,
    output logic                               busy,
    input  logic                               func,
    input  logic signed [hbc_pkg::VALUE_W-1:0] sample_value,
    input  logic [hbc_pkg::INDEX_W-1:0]        read_index,
    output logic                               done,
    output logic [hbc_pkg::INDEX_W-1:0]        bin_index,
    output logic [hbc_pkg::TOTAL_W-1:0]        bin_total
);

    import hbc_pkg::*;

    localparam int AW = $clog2(MAX_BINS);

    logic signed [VALUE_W-1:0] range_low_reg;
    logic signed [VALUE_W-1:0] range_high_reg;
    logic [BINS_W-1:0]         bins_in_use_reg;

    hbc_cls_stat_t          cls_stat;
    logic [AW-1:0]          cls_bin;
    logic                   upd_busy;
    logic                   accept;
    logic                   take_read;
    hbc_req_t               req;
    logic [AW-1:0]          req_addr;
    logic [INDEX_W-1:0]     req_index;

    logic                   ram_rd_en;
    logic [AW-1:0]          ram_rd_addr;
    logic [COUNT_WIDTH-1:0] ram_rd_data;
    logic                   ram_wr_en;
    logic [AW-1:0]          ram_wr_addr;
    logic [COUNT_WIDTH-1:0] ram_wr_data;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_low_reg   <= VALUE_W'(0);
            range_high_reg  <= VALUE_W'(327680);
            bins_in_use_reg <= BINS_W'(5);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_RANGE_LOW:   range_low_reg   <= cfg_data;
                REG_RANGE_HIGH:  range_high_reg  <= cfg_data;
                REG_BINS_IN_USE: bins_in_use_reg <= cfg_data[BINS_W-1:0];
                default:         ;
            endcase
        end
    end

    // item acceptance
    assign busy      = cls_stat.busy || upd_busy;
    assign accept    = start && !busy;
    assign take_read = accept && (func == FUNC_READ);

    hbc_classify #(
        .MAX_BINS (MAX_BINS)
    ) u_classify (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (accept && (func == FUNC_ADD)),
        .sample_value (sample_value),
        .range_low    (range_low_reg),
        .range_high   (range_high_reg),
        .bins_in_use  (bins_in_use_reg),
        .stat         (cls_stat),
        .bin          (cls_bin)
    );

    // reads go straight to the update stage, samples after classification
    assign req.valid    = take_read || cls_stat.done;
    assign req.is_read  = take_read;
    assign req.no_store = take_read && (32'(read_index) >= 32'(MAX_BINS));
    assign req_addr     = take_read ? AW'(read_index) : cls_bin;
    assign req_index    = take_read ? read_index : INDEX_W'(cls_bin);

    hbc_update #(
        .MAX_BINS    (MAX_BINS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_update (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .req_addr    (req_addr),
        .req_index   (req_index),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .busy        (upd_busy),
        .done        (done),
        .bin_index   (bin_index),
        .bin_total   (bin_total)
    );

    hbc_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (MAX_BINS)
    ) u_counts (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

### test/histogram_binning_counter_tb.sv
module histogram_binning_counter_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import hbc_pkg::*;

    localparam int TB_MAX_BINS    = DEF_MAX_BINS;
    localparam int TB_COUNT_WIDTH = DEF_COUNT_WIDTH;
    localparam longint unsigned COUNT_MAX = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - TB_COUNT_WIDTH);

    // index with no register behind it, writes there must change nothing
    localparam logic [CFG_SEL_W-1:0] REG_SPARE = 2'd3;

    localparam longint Q_MIN = -64'sd2147483648;
    localparam longint Q_MAX = 64'sd2147483647;

    localparam int SETTLE_CYCLES = 12;
    localparam int NUM_PHASES    = 10;
    localparam int PHASE_BEATS   = 195;
    localparam int MSG_CAP       = 100;

    typedef struct packed {
        logic [INDEX_W-1:0] bin;
        logic [TOTAL_W-1:0] total;
    } bin_beat_t;

    typedef enum logic {ROW_BEAT, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t            kind;
        logic                 op;
        logic [CFG_SEL_W-1:0] sel;
        logic [VALUE_W-1:0]   arg;
        bit                   typed;
        bin_beat_t            want;
    } stim_row_t;

    logic                      clk          = 1'b0;
    logic                      rst_n        = 1'b0;
    logic                      cfg_we       = 1'b0;
    logic [CFG_SEL_W-1:0]      cfg_index    = '0;
    logic [CFG_W-1:0]          cfg_data     = '0;
    logic                      start        = 1'b0;
    logic                      func         = FUNC_ADD;
    logic signed [VALUE_W-1:0] sample_value = '0;
    logic [INDEX_W-1:0]        read_index   = '0;
    logic                      busy;
    logic                      done;
    logic [INDEX_W-1:0]        bin_index;
    logic [TOTAL_W-1:0]        bin_total;

    // predictor copy of the configuration and the count store
    logic signed [31:0] range_lo = 32'sd0;
    logic signed [31:0] range_hi = 32'sd327680;
    logic [BINS_W-1:0]  bins_reg = 7'd5;
    longint unsigned    pred_counts [TB_MAX_BINS];

    bin_beat_t pending_beats [$];
    stim_row_t plan [$];

    int errors     = 0;
    int n_adds     = 0;
    int n_reads    = 0;
    int n_settings = 0;

    histogram_binning_counter #(
        .MAX_BINS    (TB_MAX_BINS),
        .COUNT_WIDTH (TB_COUNT_WIDTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .start        (start),
        .busy         (busy),
        .func         (func),
        .sample_value (sample_value),
        .read_index   (read_index),
        .done         (done),
        .bin_index    (bin_index),
        .bin_total    (bin_total)
    );

    always #1 clk = ~clk;

    // run limit
    initial
    begin
        #1_200_000;
        $display("histogram_binning_counter_tb failed");
        $finish;
    end

    // bins actually in use after the zero and overflow rules
    function automatic int unsigned eff_bins();
        if (bins_reg == 0)
            return 1;
        if (bins_reg > TB_MAX_BINS)
            return TB_MAX_BINS;
        return bins_reg;
    endfunction

    // exact floor of the scaled offset, clamped to the bins in use
    function automatic int unsigned pick_bin(logic signed [31:0] v);
        longint lo = range_lo;
        longint hi = range_hi;
        longint sv = v;
        longint nb = eff_bins();
        longint q;
        if (hi <= lo || sv < lo)
            return 0;
        q = ((sv - lo) * nb) / (hi - lo);
        if (q >= nb)
            q = nb - 1;
        return q;
    endfunction

    function automatic logic [TOTAL_W-1:0] total_of(longint unsigned c);
        if (c > 64'hFFFF_FFFF)
            return '1;
        return c[TOTAL_W-1:0];
    endfunction

    // expected result beat of one item, updates the predicted store
    function automatic bin_beat_t tally(logic op, logic signed [31:0] v, logic [INDEX_W-1:0] r);
        bin_beat_t res;
        int unsigned b;
        if (op == FUNC_ADD)
        begin
            b = pick_bin(v);
            if (pred_counts[b] < COUNT_MAX)
                pred_counts[b]++;
            res.bin   = b[INDEX_W-1:0];
            res.total = total_of(pred_counts[b]);
        end
        else
        begin
            res.bin   = r;
            res.total = (r < TB_MAX_BINS) ? total_of(pred_counts[r]) : '0;
        end
        return res;
    endfunction

    function automatic stim_row_t beat_row(logic op, logic [VALUE_W-1:0] arg);
        return '{ROW_BEAT, op, '0, arg, 1'b0, '0};
    endfunction

    function automatic stim_row_t check_row(logic op, logic [VALUE_W-1:0] arg,
                                            logic [INDEX_W-1:0] b, logic [TOTAL_W-1:0] t);
        return '{ROW_BEAT, op, '0, arg, 1'b1, '{b, t}};
    endfunction

    function automatic stim_row_t reg_row(logic [CFG_SEL_W-1:0] sel, logic [CFG_W-1:0] data);
        return '{ROW_REG, FUNC_ADD, sel, data, 1'b0, '0};
    endfunction

    function automatic longint rand_upto(longint n);
        logic [63:0] raw = {$urandom, $urandom};
        return longint'(raw % 64'(n + 1));
    endfunction

    function automatic longint rand_q16();
        logic signed [31:0] x = $urandom;
        return x;
    endfunction

    // mostly short gaps, some medium, a few long
    function automatic int pick_gap();
        int unsigned r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(3, 1);
        if (r < 97)
            return $urandom_range(12, 4);
        return $urandom_range(60, 20);
    endfunction

    // sample values: range edges, bin boundaries, the range and its margins, noise
    function automatic logic [31:0] pick_value();
        longint lo   = range_lo;
        longint hi   = range_hi;
        longint span = hi - lo;
        longint nb   = eff_bins();
        longint v;
        longint k;
        int unsigned pick = $urandom_range(99);
        if (pick < 15)
            return $urandom;
        if (pick < 30)
        begin
            case ($urandom_range(7))
                0: v = lo - 1;
                1: v = lo;
                2: v = lo + 1;
                3: v = hi - 1;
                4: v = hi;
                5: v = hi + 1;
                6: v = Q_MIN;
                default: v = Q_MAX;
            endcase
        end
        else if (span <= 0)
            v = lo - 1000 + rand_upto(2000);
        else if (pick < 55)
        begin
            k = rand_upto(nb);
            v = lo + (k * span + nb - 1) / nb - longint'($urandom_range(1));
        end
        else
            v = lo - span / 16 + rand_upto(span + span / 8);
        if (v < Q_MIN)
            v = Q_MIN;
        if (v > Q_MAX)
            v = Q_MAX;
        return v[31:0];
    endfunction

    function automatic logic [INDEX_W-1:0] pick_read();
        if ($urandom_range(1) == 0)
            return $urandom_range(63);
        return $urandom_range(eff_bins() - 1);
    endfunction

    // one item beat; start stays high afterwards unless the next call idles
    task automatic send_beat(input logic op, input logic [31:0] v, input logic [INDEX_W-1:0] r,
                             input int gap, input bit typed, input bin_beat_t want);
        bin_beat_t predicted;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start        <= 1'b1;
        func         <= op;
        sample_value <= v;
        read_index   <= r;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        predicted = tally(op, v, r);
        pending_beats.push_back(typed ? want : predicted);
        if (op == FUNC_ADD)
            n_adds++;
        else
            n_reads++;
    endtask

    // hold off until every result is back and the block is idle
    task automatic settle();
        start <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy !== 1'b0)
            @(posedge clk);
    endtask

    // caller lowers cfg_we after the last write of a group
    task automatic write_reg(input logic [CFG_SEL_W-1:0] sel, input logic [CFG_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= sel;
        cfg_data  <= data;
        @(posedge clk);
        case (sel)
            REG_RANGE_LOW:   range_lo = data;
            REG_RANGE_HIGH:  range_hi = data;
            REG_BINS_IN_USE: bins_reg = data[BINS_W-1:0];
            default: ;
        endcase
    endtask

    // register setting of one random phase
    task automatic set_phase_regs(input int mode);
        longint a;
        longint b;
        longint lo;
        longint hi;
        logic [CFG_W-1:0] bins_d;
        a = rand_q16();
        b = rand_q16();
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
        bins_d = $urandom_range(64, 1);
        case (mode)
            0:
            begin
                lo = 0;
                hi = 327680;
                bins_d = 5;
            end
            1:
            begin
                lo = Q_MIN;
                hi = Q_MAX;
                bins_d = 64;
            end
            2:
            begin
                // empty range, high equal to or below low
                lo = a;
                hi = ($urandom_range(1) == 0) ? a : a - rand_upto(a - Q_MIN);
            end
            3:
            begin
                // zero bins, with junk above the register width
                bins_d = $urandom;
                bins_d[BINS_W-1:0] = '0;
            end
            4: bins_d = $urandom_range(127, 65);
            5: bins_d = 1;
            6: bins_d = $urandom;
            7:
            begin
                lo = a;
                hi = b;
                bins_d = $urandom;
                bins_d[BINS_W-1:0] = $urandom_range(64, 1);
            end
            8:
            begin
                // span of at most 100, often narrower than the bin count
                lo = Q_MIN + rand_upto(Q_MAX - Q_MIN - 100);
                hi = lo + $urandom_range(100, 1);
                bins_d = 64;
            end
            default:
            begin
                lo = -6553600 + rand_upto(13107200);
                hi = lo + 1 + rand_upto(3276800);
            end
        endcase
        write_reg(REG_RANGE_LOW, lo[31:0]);
        write_reg(REG_RANGE_HIGH, hi[31:0]);
        write_reg(REG_BINS_IN_USE, bins_d);
        if ($urandom_range(1) == 0)
            write_reg(REG_SPARE, $urandom);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // result beats against the oldest expectation
    always @(posedge clk)
    begin : watch_results
        bin_beat_t want;
        if (rst_n === 1'b1 && done === 1'b1)
        begin
            if (pending_beats.size() == 0)
            begin
                errors++;
                if (errors <= MSG_CAP)
                    $display("%0t: unexpected result beat, bin %0d total %0d",
                             $time, bin_index, bin_total);
            end
            else
            begin
                want = pending_beats.pop_front();
                if (bin_index !== want.bin)
                begin
                    errors++;
                    if (errors <= MSG_CAP)
                        $display("%0t: bin_index expected %0d actual %0d",
                                 $time, want.bin, bin_index);
                end
                if (bin_total !== want.total)
                begin
                    errors++;
                    if (errors <= MSG_CAP)
                        $display("%0t: bin_total expected %0d actual %0d (bin %0d)",
                                 $time, want.total, bin_total, want.bin);
                end
            end
        end
    end

    initial
    begin : drive
        bit cfg_open;
        int pause_at;
        bit calm;
        int gap;
        cfg_open = 1'b0;
        foreach (pred_counts[i])
            pred_counts[i] = 0;

        // directed rows, defaults are range 0.0 to 5.0 in five bins
        // typed expectations hold for the reset state, the range extremes and the bin boundaries
        plan = '{
            check_row(FUNC_READ, 32'd0, 6'd0, 32'd0),
            check_row(FUNC_READ, 32'd63, 6'd63, 32'd0),
            check_row(FUNC_ADD, 32'h0000_0000, 6'd0, 32'd1),
            check_row(FUNC_ADD, 32'hFFFF_FFFF, 6'd0, 32'd2),
            check_row(FUNC_ADD, 32'h8000_0000, 6'd0, 32'd3),
            check_row(FUNC_ADD, 32'h7FFF_FFFF, 6'd4, 32'd1),
            check_row(FUNC_ADD, 32'h0005_0000, 6'd4, 32'd2),
            check_row(FUNC_ADD, 32'h0004_FFFF, 6'd4, 32'd3),
            check_row(FUNC_ADD, 32'h0000_FFFF, 6'd0, 32'd4),
            check_row(FUNC_ADD, 32'h0001_0000, 6'd1, 32'd1),
            check_row(FUNC_READ, 32'd4, 6'd4, 32'd3),
            check_row(FUNC_READ, 32'd5, 6'd5, 32'd0),
            reg_row(REG_BINS_IN_USE, 32'hFFFF_FF80),
            beat_row(FUNC_ADD, 32'h0004_93E0),
            reg_row(REG_BINS_IN_USE, 32'h0000_007F),
            beat_row(FUNC_ADD, 32'h0004_FFFF),
            beat_row(FUNC_ADD, 32'h0000_1400),
            beat_row(FUNC_ADD, 32'h0000_13FF),
            reg_row(REG_RANGE_HIGH, 32'h0000_0000),
            reg_row(REG_SPARE, 32'hA5A5_5A5A),
            beat_row(FUNC_ADD, 32'h0000_0064),
            reg_row(REG_RANGE_LOW, 32'h0001_0000),
            reg_row(REG_RANGE_HIGH, 32'hFFFF_0000),
            beat_row(FUNC_ADD, 32'h0002_0000),
            reg_row(REG_RANGE_LOW, 32'h8000_0000),
            reg_row(REG_RANGE_HIGH, 32'h7FFF_FFFF),
            reg_row(REG_BINS_IN_USE, 32'd64),
            beat_row(FUNC_ADD, 32'h7FFF_FFFF),
            beat_row(FUNC_ADD, 32'h8000_0000),
            beat_row(FUNC_ADD, 32'h0000_0000),
            beat_row(FUNC_ADD, 32'hFFFF_FFFF),
            reg_row(REG_BINS_IN_USE, 32'd1),
            beat_row(FUNC_ADD, 32'h0000_3039),
            beat_row(FUNC_READ, 32'd63),
            beat_row(FUNC_READ, 32'd32)
        };

        // reset, then the block sweeps its count memory
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // directed part
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
            begin
                if (!cfg_open)
                    settle();
                cfg_open = 1'b1;
                write_reg(plan[i].sel, plan[i].arg);
            end
            else
            begin
                if (cfg_open)
                begin
                    cfg_we <= 1'b0;
                    n_settings++;
                end
                cfg_open = 1'b0;
                if (plan[i].op == FUNC_READ)
                    send_beat(plan[i].op, $urandom, plan[i].arg[INDEX_W-1:0], pick_gap(),
                              plan[i].typed, plan[i].want);
                else
                    send_beat(plan[i].op, plan[i].arg, $urandom_range(63), pick_gap(),
                              plan[i].typed, plan[i].want);
            end
        end

        // random phases, one register setting each
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            settle();
            set_phase_regs(ph);
            calm = ($urandom_range(3) == 0);
            pause_at = $urandom_range(PHASE_BEATS - 1);
            for (int k = 0; k < PHASE_BEATS; k++)
            begin
                // sender holds off until the pipeline is empty
                if (k == pause_at)
                    settle();
                gap = calm ? 0 : pick_gap();
                if ($urandom_range(3) == 0)
                    send_beat(FUNC_READ, $urandom, pick_read(), gap, 1'b0, '0);
                else
                    send_beat(FUNC_ADD, pick_value(), $urandom_range(63), gap, 1'b0, '0);
            end
        end

        // drain and report
        start <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("covered %0d sample beats and %0d read beats over %0d register settings",
                 n_adds, n_reads, n_settings);
        $display("settings included full span, empty range, zero and oversized bin counts");
        if (errors == 0)
            $display("histogram_binning_counter_tb passed");
        else
            $display("histogram_binning_counter_tb failed");
        $finish;
    end

endmodule
